// File: src/hbd_pkg.sv
// shared types, constants and helper functions for the http body deframer
// no dependencies; imported by every module of the block

package hbd_pkg;

  localparam int SIZE_BITS = 32;
  localparam int CNT_W     = 32;
  localparam int REM_W     = (SIZE_BITS > CNT_W) ? SIZE_BITS : CNT_W;
  localparam int TDATA_W   = 48;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // configuration register indexes
  localparam logic REG_BODY_MODE   = 1'b0;
  localparam logic REG_BODY_LENGTH = 1'b1;

  localparam logic MODE_LENGTH  = 1'b0;
  localparam logic MODE_CHUNKED = 1'b1;

  typedef enum logic [3:0] {
    PH_SIZE = 4'b0001,
    PH_DATA = 4'b0010,
    PH_SKIP = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0]       body_byte;
    logic             byte_valid;
    logic             body_done;
    logic [CNT_W-1:0] total_bytes;
    logic             size_error;
  } result_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {[8'h09:8'h0D], 8'h20};
  endfunction

endpackage

// File: src/hbd_core.sv
// per-byte decode: configuration registers, body state and the result of each beat
// depends on hbd_pkg

module hbd_core
  import hbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_fire,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic             in_fire,
  input  logic [7:0]       data_byte,
  input  logic             new_message,
  output logic             res_valid,
  output result_t          res
);

  logic             body_mode;
  logic [CNT_W-1:0] body_length;

  phase_t               phase, phase_next;
  logic [REM_W-1:0]     bytes_remaining, bytes_remaining_next;
  logic [SIZE_BITS-1:0] size_accumulator, size_accumulator_next;
  logic                 digits_closed, digits_closed_next;
  logic                 digits_started, digits_started_next;
  logic                 previous_was_cr, previous_was_cr_next;
  logic [1:0]           skip_count, skip_count_next;
  logic [CNT_W-1:0]     delivered_count, delivered_count_next;
  logic                 overflow_seen, overflow_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_mode   <= MODE_CHUNKED;
      body_length <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_BODY_MODE:   body_mode <= cfg_data[0];
        REG_BODY_LENGTH: body_length <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [REM_W-1:0] rem;
    logic [4:0]       hx;
    logic             do_deliver;

    phase_next            = phase;
    bytes_remaining_next  = bytes_remaining;
    size_accumulator_next = size_accumulator;
    digits_closed_next    = digits_closed;
    digits_started_next   = digits_started;
    previous_was_cr_next  = previous_was_cr;
    skip_count_next       = skip_count;
    delivered_count_next  = delivered_count;
    overflow_seen_next    = overflow_seen;
    do_deliver            = 1'b0;
    rem                   = bytes_remaining;
    hx                    = hex_digit(data_byte);
    res_valid             = 1'b0;
    res.body_byte         = 8'd0;
    res.byte_valid        = 1'b0;
    res.body_done         = 1'b0;

    // a new message starts from a cleared body
    if (new_message) begin
      phase_next            = PH_SIZE;
      rem                   = '0;
      size_accumulator_next = '0;
      digits_closed_next    = 1'b0;
      digits_started_next   = 1'b0;
      previous_was_cr_next  = 1'b0;
      skip_count_next       = 2'd0;
      delivered_count_next  = '0;
      overflow_seen_next    = 1'b0;
    end
    bytes_remaining_next = rem;

    case (phase_next)
      PH_DATA: do_deliver = 1'b1;
      PH_SKIP: begin
        if (skip_count_next != 2'd0) skip_count_next = skip_count_next - 2'd1;
        if (skip_count_next == 2'd0) begin
          phase_next            = PH_SIZE;
          size_accumulator_next = '0;
          digits_closed_next    = 1'b0;
          digits_started_next   = 1'b0;
          previous_was_cr_next  = 1'b0;
        end
      end
      PH_DONE: ;
      PH_SIZE: begin
        if (body_mode == MODE_LENGTH) begin
          size_accumulator_next = '0;
          digits_closed_next    = 1'b0;
          digits_started_next   = 1'b0;
          previous_was_cr_next  = 1'b0;
          rem                   = REM_W'(body_length);
          bytes_remaining_next  = rem;
          if (body_length == '0) begin
            phase_next    = PH_DONE;
            res_valid     = 1'b1;
            res.body_done = 1'b1;
          end else begin
            phase_next = PH_DATA;
            do_deliver = 1'b1;
          end
        end else if (previous_was_cr_next && data_byte == CHAR_LF) begin
          // a restart clears the cr flag, so the accumulator here is the line's own
          size_accumulator_next = '0;
          digits_closed_next    = 1'b0;
          digits_started_next   = 1'b0;
          previous_was_cr_next  = 1'b0;
          if (size_accumulator == '0) begin
            phase_next    = PH_DONE;
            res_valid     = 1'b1;
            res.body_done = 1'b1;
          end else begin
            bytes_remaining_next = REM_W'(size_accumulator);
            phase_next           = PH_DATA;
          end
        end else begin
          previous_was_cr_next = (data_byte == CHAR_CR);
          if (!digits_closed_next) begin
            if (hx[4]) begin
              digits_started_next = 1'b1;
              // saturate once a further digit would shift ones out of the top
              if (size_accumulator_next[SIZE_BITS-1 -: 4] != 4'd0) begin
                size_accumulator_next = '1;
                overflow_seen_next    = 1'b1;
              end else begin
                size_accumulator_next = {size_accumulator_next[SIZE_BITS-5:0], hx[3:0]};
              end
            end else if (!(is_blank(data_byte) && !digits_started_next)) begin
              digits_closed_next = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    if (do_deliver) begin
      if (delivered_count_next != '1) delivered_count_next = delivered_count_next + 1'b1;
      if (rem != '0) rem = rem - 1'b1;
      bytes_remaining_next = rem;
      res_valid            = 1'b1;
      res.body_byte        = data_byte;
      res.byte_valid       = 1'b1;
      if (rem == '0) begin
        if (body_mode != MODE_LENGTH) begin
          phase_next      = PH_SKIP;
          skip_count_next = 2'd2;
        end else begin
          phase_next    = PH_DONE;
          res.body_done = 1'b1;
        end
      end
    end

    res.total_bytes = delivered_count_next;
    res.size_error  = overflow_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SIZE;
      bytes_remaining  <= '0;
      size_accumulator <= '0;
      digits_closed    <= 1'b0;
      digits_started   <= 1'b0;
      previous_was_cr  <= 1'b0;
      skip_count       <= 2'd0;
      delivered_count  <= '0;
      overflow_seen    <= 1'b0;
    end else if (in_fire) begin
      phase            <= phase_next;
      bytes_remaining  <= bytes_remaining_next;
      size_accumulator <= size_accumulator_next;
      digits_closed    <= digits_closed_next;
      digits_started   <= digits_started_next;
      previous_was_cr  <= previous_was_cr_next;
      skip_count       <= skip_count_next;
      delivered_count  <= delivered_count_next;
      overflow_seen    <= overflow_seen_next;
    end
  end

endmodule

// File: src/hbd_out_stage.sv
// result register with a skid entry so the input can take one further result while the receiver stalls
// depends on hbd_pkg

module hbd_out_stage
  import hbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_valid;
  result_t main_data;
  logic    skid_valid;
  result_t skid_data;
  logic    in_fire;

  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !main_valid) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !main_valid) begin
      main_data <= skid_valid ? skid_data : in_data;
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

endmodule

// File: src/http_body_deframer.sv
// http body deframer: takes body bytes, passes on payload bytes in length or chunked mode
// depends on hbd_pkg, hbd_core and hbd_out_stage
//
// usage:
//   s_* carries one received body byte per beat; s_tuser set restarts decoding
//   with that byte as the first body byte. m_* carries at most one result per
//   input beat: m_tuser says whether the beat holds a payload byte, m_tlast
//   marks the last result of the body. cfg_* writes body_mode (index 0) and
//   the body length (index 1); cfg_ready is always high. the user must write them
//   only while the block is idle; the block itself does not enforce this. results
//   are registered. throughput: one byte per cycle while s_tready is high; the
//   state update and hex shift-add of one byte sit between the state registers
//   and the result register. when the receiver stalls, one further result is held
//   in a skid entry and s_tready then drops until the result register drains.
//   reset clears the body state to the size line phase, selects chunked mode,
//   sets the body length to zero and empties the result register.

module http_body_deframer
  import hbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] data_byte
  input  logic               s_tuser,   // [0] new_message
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [7:0] body_byte, [39:8] total_bytes, [40] size_error
  output logic               m_tuser,   // [0] byte_valid
  output logic               m_tlast,   // body_done
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  logic    in_fire;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;

  hbd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_fire    (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_fire     (in_fire),
    .data_byte   (s_tdata),
    .new_message (s_tuser),
    .res_valid   (res_valid),
    .res         (res)
  );

  hbd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_fire && res_valid),
    .in_ready  (s_tready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {{(TDATA_W - CNT_W - 9){1'b0}}, out_res.size_error,
                    out_res.total_bytes, out_res.body_byte};
  assign m_tuser = out_res.byte_valid;
  assign m_tlast = out_res.body_done;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present right after reset");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("result without payload byte is not the end of a body");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
    else $error("result without payload byte carries a nonzero byte");

endmodule

// File: dv/hbd_deframe_check.sv
`timescale 1ns / 100ps
// scoreboard for http_body_deframer: mirrors the length and chunked decoding of
// every accepted input beat and checks each result beat in order; uses hbd_pkg

module hbd_deframe_check
  import hbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [7:0]         s_tdata,
  input  logic               s_tuser,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [TDATA_W-1:0] m_tdata,
  input  logic               m_tuser,
  input  logic               m_tlast,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending
);

  result_t     expected_q[$];
  result_t     want;
  int          fail_count = 0;

  // register copies
  logic        mode_r;
  logic [31:0] clen_r;

  // decoder copy
  phase_t      ph;
  logic [31:0] remain;
  logic [31:0] acc;
  logic [31:0] delivered;
  logic        closed;
  logic        started;
  logic        was_cr;
  logic        ovf;
  logic [1:0]  skip;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic int hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  task automatic clear_line();
    acc     = '0;
    closed  = 1'b0;
    started = 1'b0;
    was_cr  = 1'b0;
  endtask

  task automatic clear_body();
    ph        = PH_SIZE;
    remain    = '0;
    clear_line();
    skip      = 2'd0;
    delivered = '0;
    ovf       = 1'b0;
  endtask

  task automatic expect_beat(input logic [7:0] b, input logic valid, input logic done);
    result_t r;
    r.body_byte   = valid ? b : 8'h00;
    r.byte_valid  = valid;
    r.body_done   = done;
    r.total_bytes = delivered;
    r.size_error  = ovf;
    expected_q.push_back(r);
  endtask

  task automatic pass_payload(input logic [7:0] b);
    logic done;
    done = 1'b0;
    if (delivered != '1) delivered = delivered + 1;
    if (remain != 0) remain = remain - 1;
    if (remain == 0) begin
      if (mode_r == MODE_CHUNKED) begin
        ph   = PH_SKIP;
        skip = 2'd2;
      end else begin
        ph   = PH_DONE;
        done = 1'b1;
      end
    end
    expect_beat(b, 1'b1, done);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic restart);
    int          h;
    logic [31:0] line_len;
    if (restart) clear_body();
    case (ph)
      PH_DATA: pass_payload(b);
      PH_SKIP: begin
        if (skip != 0) skip = skip - 2'd1;
        if (skip == 0) begin
          ph = PH_SIZE;
          clear_line();
        end
      end
      PH_DONE: ;
      default: begin
        if (mode_r == MODE_LENGTH) begin
          // length mode starts the body on its first byte
          clear_line();
          remain = clen_r;
          if (remain == 0) begin
            ph = PH_DONE;
            expect_beat(8'h00, 1'b0, 1'b1);
          end else begin
            ph = PH_DATA;
            pass_payload(b);
          end
        end else if (was_cr && b == CHAR_LF) begin
          line_len = acc;
          clear_line();
          if (line_len == 0) begin
            ph = PH_DONE;
            expect_beat(8'h00, 1'b0, 1'b1);
          end else begin
            remain = line_len;
            ph     = PH_DATA;
          end
        end else begin
          was_cr = (b == CHAR_CR);
          if (!closed) begin
            h = hex_val(b);
            if (h >= 0) begin
              started = 1'b1;
              if (acc[31:28] != 4'h0) begin
                acc = '1;
                ovf = 1'b1;
              end else begin
                acc = {acc[27:0], h[3:0]};
              end
            end else if (!(blank_char(b) && !started)) begin
              closed = 1'b1;
            end
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_r = MODE_CHUNKED;
      clen_r = '0;
      clear_body();
      expected_q.delete();
    end else begin
      // results first: a beat accepted at this edge cannot have answered yet
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[7:0] !== want.body_byte)
            report($sformatf("body_byte %0h, expected %0h", m_tdata[7:0], want.body_byte));
          if (m_tuser !== want.byte_valid)
            report($sformatf("byte_valid %0b, expected %0b", m_tuser, want.byte_valid));
          if (m_tlast !== want.body_done)
            report($sformatf("body_done %0b, expected %0b", m_tlast, want.body_done));
          if (m_tdata[39:8] !== want.total_bytes)
            report($sformatf("total_bytes %0h, expected %0h", m_tdata[39:8],
                             want.total_bytes));
          if (m_tdata[40] !== want.size_error)
            report($sformatf("size_error %0b, expected %0b", m_tdata[40], want.size_error));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BODY_MODE) mode_r = cfg_data[0];
        else clen_r = cfg_data;
      end
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser);
    end
    errors  <= fail_count;
    pending <= expected_q.size();
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// top of the http_body_deframer bench: drives body bytes and register writes
// with random gaps and stalls; hbd_deframe_check does the checking; uses hbd_pkg

module testbench;
  import hbd_pkg::*;

  localparam int ITEMS       = 1050;
  localparam int CYCLE_LIMIT = 200000;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               s_tvalid  = 1'b0;
  logic [7:0]         s_tdata   = 8'h00;
  logic               s_tuser   = 1'b0;
  logic               m_tready  = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_index = REG_BODY_MODE;
  logic [31:0]        cfg_data  = '0;
  logic               s_tready;
  logic               m_tvalid;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tuser;
  logic               m_tlast;
  logic               cfg_ready;

  int         errors;
  int         pending;
  int         beats_sent = 0;
  int         cycles     = 0;
  bit         calm       = 1'b0;
  logic [7:0] msg[$];
  logic [7:0] carry[$];

  always #10 clk = ~clk;

  http_body_deframer uut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  hbd_deframe_check deframe_check (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending
  );

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic restart);
    if (!calm && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
  endtask

  // hold the sender until every expected result beat is out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'h30 + v;
    return (($urandom_range(1) == 1) ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endtask

  task automatic add_random(input int n);
    repeat (n) msg.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_chunk(input int unsigned len);
    int ndig;
    repeat ($urandom_range(2)) begin
      case ($urandom_range(4))
        0: msg.push_back(8'h20);
        1: msg.push_back(8'h09);
        2: msg.push_back(8'h0B);
        3: msg.push_back(8'h0C);
        default: msg.push_back(CHAR_CR);
      endcase
    end
    ndig = 1;
    while ((len >> (4 * ndig)) != 0 && ndig < 8) ndig++;
    if ($urandom_range(3) == 0) ndig++;
    for (int i = ndig - 1; i >= 0; i--) msg.push_back(hex_char(4'(len >> (4 * i))));
    // chunk extension, ignored up to the line end
    if ($urandom_range(3) == 0) begin
      msg.push_back(8'h3B);
      repeat ($urandom_range(4)) msg.push_back(8'($urandom_range(8'h7E, 8'h21)));
    end
    add_text("\r\n");
    add_random(len);
    if ($urandom_range(4) == 0) add_random(2);
    else add_text("\r\n");
  endtask

  task automatic build_chunked();
    msg.delete();
    repeat ($urandom_range(3))
      add_chunk(($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1));
    case ($urandom_range(7))
      0: add_text("0\r\n");
      1: add_text("\r\n");
      2: add_text("0x1A\r\n");
      3: add_text("-7\r\n");
      4: add_text(" +3 ;x\r\n");
      5: add_text("000;q\r\n");
      6: begin
        // oversized count, body runs until the next restart
        add_text("fFfFfFfFf1\r\n");
        add_random($urandom_range(6, 1));
      end
      default: begin
        // lone cr closes the digits, the 5 is ignored
        add_text("4\r5\r\n");
        add_random(4);
        add_text("\r\n0\r\n");
      end
    endcase
    add_random($urandom_range(3));
  endtask

  task automatic build_length(input logic [31:0] clen);
    msg.delete();
    if (clen <= 64) add_random(clen);
    else add_random($urandom_range(20, 1));
    add_random($urandom_range(3));
    if (msg.size() == 0) add_random(1);
  endtask

  task automatic send_msg(input int upto, input logic restart);
    for (int i = 0; i < upto; i++) put_byte(msg[i], restart && i == 0);
  endtask

  initial begin
    logic        mode;
    logic [31:0] clen;
    int          nmsg;
    int          cut;
    int          directed_end;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // chunked out of reset: blank, extension, data, trailing crlf, empty line
    msg.delete();
    add_text(" 2;e\r\nXY\r\n\r\n");
    send_msg(msg.size(), 1'b0);
    drain();

    // size line overflow, error flag rides on the payload
    msg.delete();
    add_text("fffffffff\r\n");
    msg.push_back(8'h00);
    send_msg(msg.size(), 1'b1);
    drain();

    // length mode, zero length ends at once and the next byte is dropped
    write_reg(REG_BODY_MODE, {31'd0, MODE_LENGTH});
    write_reg(REG_BODY_LENGTH, 32'd0);
    msg.delete();
    msg.push_back(8'hFF);
    msg.push_back(8'h55);
    send_msg(msg.size(), 1'b1);
    drain();

    write_reg(REG_BODY_LENGTH, 32'd2);
    msg.delete();
    msg.push_back(8'h00);
    msg.push_back(8'hFF);
    send_msg(msg.size(), 1'b1);

    directed_end = beats_sent;
    for (int ph_i = 0; beats_sent < directed_end + ITEMS; ph_i++) begin
      drain();
      mode = 1'($urandom_range(1));
      case ($urandom_range(9))
        0: clen = '0;
        1: clen = '1;
        2: clen = $urandom;
        default: clen = $urandom_range(24, 1);
      endcase
      write_reg(REG_BODY_MODE, {31'd0, mode});
      write_reg(REG_BODY_LENGTH, clen);
      calm = (ph_i >= 6 && ph_i < 10);

      // tail of a body cut at the last phase, now under the new settings
      foreach (carry[i]) put_byte(carry[i], 1'b0);
      carry.delete();

      nmsg = $urandom_range(6, 2);
      for (int k = 0; k < nmsg; k++) begin
        if ($urandom_range(9) == 0) begin
          msg.delete();
          add_random($urandom_range(8, 1));
        end else if (mode == MODE_CHUNKED) begin
          build_chunked();
        end else begin
          build_length(clen);
        end
        cut = msg.size();
        if (k == nmsg - 1 && cut > 1 && $urandom_range(2) == 0)
          cut = $urandom_range(msg.size() - 1, 1);
        send_msg(cut, 1'b1);
        for (int i = cut; i < msg.size(); i++) carry.push_back(msg[i]);
      end
    end

    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
